@@ rtl/core/plf_pkg.sv @@
// ----------------------------------------------------------------------------
// plf_pkg
// Shared constants and status codes of the plane fit block.
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int unsigned MaxPointsDef    = 1024;
  localparam int unsigned CoordBitsDef    = 16;
  localparam int unsigned CoefFracBitsDef = 16;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StFew      = 3'd1;
  localparam logic [StatusW-1:0] StSingular = 3'd2;
  localparam logic [StatusW-1:0] StNegative = 3'd3;
  localparam logic [StatusW-1:0] StTooMany  = 3'd4;

endpackage

@@ rtl/core/plf_mul.sv @@
// ----------------------------------------------------------------------------
// plf_mul
// Bit-serial signed multiplier, one shift-add per cycle.
// ----------------------------------------------------------------------------
module plf_mul
  import plf_pkg::*;
#(
  parameter int unsigned SumW = 42
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [SumW-1:0]   a_i,
  input  logic signed [SumW-1:0]   b_i,
  output logic                     done_o,
  output logic signed [2*SumW:0]   p_o
);

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0] mag_a_q, mag_a_d;
  logic [SumW-1:0] hi_q, hi_d;
  logic [SumW-1:0] lo_q, lo_d;
  logic            neg_q, neg_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW:0]   sum;
  logic [2*SumW:0] prod;

  always_comb begin
    sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mag_a_q} : '0);
    mag_a_d = mag_a_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    neg_d   = neg_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    if (start_i) begin
      mag_a_d = a_i[SumW-1] ? SumW'(-a_i) : SumW'(a_i);
      lo_d    = b_i[SumW-1] ? SumW'(-b_i) : SumW'(b_i);
      hi_d    = '0;
      neg_d   = a_i[SumW-1] ^ b_i[SumW-1];
      busy_d  = 1'b1;
      cnt_d   = '0;
    end else if (busy_q) begin
      hi_d  = sum[SumW:1];
      lo_d  = {sum[0], lo_q[SumW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_a_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    neg_q   <= neg_d;
  end

  assign prod   = {1'b0, hi_q, lo_q};
  assign p_o    = neg_q ? -$signed(prod) : $signed(prod);
  assign done_o = done_q;

endmodule

@@ rtl/core/plf_div.sv @@
// ----------------------------------------------------------------------------
// plf_div
// Restoring divider, one quotient bit per cycle, saturated fixed-point result.
// ----------------------------------------------------------------------------
module plf_div
  import plf_pkg::*;
#(
  parameter int unsigned PW       = 85,
  parameter int unsigned FracBits = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PW-1:0]    num_i,
  input  logic [PW-1:0]    den_i,
  output logic             done_o,
  output logic [CoefW-1:0] quot_o
);

  localparam int unsigned NW   = PW + FracBits;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]    num_q, num_d;
  logic [PW-1:0]    den_q, den_d;
  logic [PW-1:0]    rem_q, rem_d;
  logic [CoefW-1:0] q_q, q_d;
  logic             sat_q, sat_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PW:0]      trial;
  logic [PW:0]      diff;

  always_comb begin
    trial  = {rem_q, num_q[NW-1]};
    diff   = trial - {1'b0, den_q};
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    q_d    = q_q;
    sat_d  = sat_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      num_d  = {num_i, {FracBits{1'b0}}};
      den_d  = den_i;
      rem_d  = '0;
      q_d    = '0;
      sat_d  = 1'b0;
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], 1'b0};
      if (!diff[PW]) begin
        rem_d = diff[PW-1:0];
      end else begin
        rem_d = trial[PW-1:0];
      end
      q_d   = {q_q[CoefW-2:0], ~diff[PW]};
      sat_d = sat_q | q_q[CoefW-1];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    q_q   <= q_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? '1 : q_q;

endmodule

@@ rtl/core/least_squares_plane_fit.sv @@
// ----------------------------------------------------------------------------
// least_squares_plane_fit
// Fits z = a*x + b*y through the origin over a stream of points.
//
// channel  | dir | tdata                      | tuser       | tlast
// s_axis   | in  | point_x, point_y, point_z  | -           | last_point
// m_axis   | out | coef_a, coef_b             | fit_status  | -
//
// Each point takes five multiply-accumulates through one multiplier; no new
// point is taken until they are done. A last point adds the solve: six
// serial products and two serial divides. Reset clears all sums. A waiting
// result holds while new points are taken; the next solve runs, but its
// result waits until the first one is taken.
// ----------------------------------------------------------------------------
module least_squares_plane_fit
  import plf_pkg::*;
#(
  parameter int unsigned MAX_POINTS     = MaxPointsDef,
  parameter int unsigned COORD_BITS     = CoordBitsDef,
  parameter int unsigned COEF_FRAC_BITS = CoefFracBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // point_x, point_y, point_z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // coef_a, coef_b
  output logic [2*CoefW-1:0]                    m_axis_tdata,
  // fit_status
  output logic [StatusW-1:0]                    m_axis_tuser
);

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SumW = 2 * COORD_BITS + CntW;
  localparam int unsigned PW   = 2 * SumW + 1;
  localparam int unsigned CB   = COORD_BITS;

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SAcc   = 7'b0000010,
    SCheck = 7'b0000100,
    SMul   = 7'b0001000,
    SEval  = 7'b0010000,
    SDiv   = 7'b0100000,
    SDone  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [CB-1:0]   x_q, y_q, z_q;
  logic                   last_q;
  logic signed [SumW-1:0] sxx_q, syy_q, sxy_q, sxz_q, syz_q;
  logic signed [SumW-1:0] sxx_d, syy_d, sxy_d, sxz_d, syz_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [2:0]             step_q, step_d;
  logic signed [PW-1:0]   tmp_q, tmp_d, det_q, det_d, na_q, na_d, nb_q, nb_d;
  logic [CoefW-1:0]       ra_q, ra_d, rb_q, rb_d;
  logic [StatusW-1:0]     rs_q, rs_d;
  logic                   mstart_q, mstart_d, dstart_q, dstart_d;
  logic                   ov_q, ov_d;
  logic [2*CoefW-1:0]     odata_q, odata_d;
  logic [StatusW-1:0]     ouser_q, ouser_d;

  logic signed [CB-1:0]   op_a, op_b;
  logic signed [2*CB-1:0] prod;
  logic signed [SumW-1:0] prod_x;
  logic signed [SumW-1:0] mul_a, mul_b;
  logic                   mul_done, div_done;
  logic signed [PW-1:0]   mul_p;
  logic [PW-1:0]          div_num, det_mag;
  logic [CoefW-1:0]       div_q;
  logic                   accept, nega, negb;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == SIdle);

  always_comb begin
    unique case (step_q)
      3'd0:    begin op_a = x_q; op_b = x_q; end
      3'd1:    begin op_a = y_q; op_b = y_q; end
      3'd2:    begin op_a = x_q; op_b = y_q; end
      3'd3:    begin op_a = x_q; op_b = z_q; end
      default: begin op_a = y_q; op_b = z_q; end
    endcase
  end

  assign prod   = op_a * op_b;
  assign prod_x = SumW'(prod);

  always_comb begin
    unique case (step_q)
      3'd0:    begin mul_a = sxx_q; mul_b = syy_q; end
      3'd1:    begin mul_a = sxy_q; mul_b = sxy_q; end
      3'd2:    begin mul_a = sxz_q; mul_b = syy_q; end
      3'd3:    begin mul_a = syz_q; mul_b = sxy_q; end
      3'd4:    begin mul_a = syz_q; mul_b = sxx_q; end
      default: begin mul_a = sxz_q; mul_b = sxy_q; end
    endcase
  end

  plf_mul #(
    .SumW(SumW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mstart_q),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign det_mag = det_q[PW-1] ? PW'(-det_q) : PW'(det_q);
  assign div_num = (step_q == 3'd0) ? (na_q[PW-1] ? PW'(-na_q) : PW'(na_q))
                                    : (nb_q[PW-1] ? PW'(-nb_q) : PW'(nb_q));

  plf_div #(
    .PW      (PW),
    .FracBits(COEF_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart_q),
    .num_i  (div_num),
    .den_i  (det_mag),
    .done_o (div_done),
    .quot_o (div_q)
  );

  assign nega = (na_q != '0) && (na_q[PW-1] ^ det_q[PW-1]);
  assign negb = (nb_q != '0) && (nb_q[PW-1] ^ det_q[PW-1]);

  always_comb begin
    state_d  = state_q;
    sxx_d    = sxx_q;
    syy_d    = syy_q;
    sxy_d    = sxy_q;
    sxz_d    = sxz_q;
    syz_d    = syz_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    step_d   = step_q;
    tmp_d    = tmp_q;
    det_d    = det_q;
    na_d     = na_q;
    nb_d     = nb_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    rs_d     = rs_q;
    mstart_d = 1'b0;
    dstart_d = 1'b0;
    ov_d     = ov_q;
    odata_d  = odata_q;
    ouser_d  = ouser_q;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          step_d = '0;
          if (cnt_q < CntW'(MAX_POINTS)) begin
            cnt_d   = cnt_q + 1'b1;
            state_d = SAcc;
          end else begin
            ovf_d   = 1'b1;
            state_d = s_axis_tlast ? SCheck : SIdle;
          end
        end
      end
      SAcc: begin
        step_d = step_q + 1'b1;
        case (step_q)
          3'd0:    sxx_d = sxx_q + prod_x;
          3'd1:    syy_d = syy_q + prod_x;
          3'd2:    sxy_d = sxy_q + prod_x;
          3'd3:    sxz_d = sxz_q + prod_x;
          default: syz_d = syz_q + prod_x;
        endcase
        if (step_q == 3'd4) begin
          state_d = last_q ? SCheck : SIdle;
        end
      end
      SCheck: begin
        step_d = '0;
        ra_d   = '0;
        rb_d   = '0;
        if (ovf_q) begin
          rs_d    = StTooMany;
          state_d = SDone;
        end else if (cnt_q < CntW'(3)) begin
          rs_d    = StFew;
          state_d = SDone;
        end else begin
          mstart_d = 1'b1;
          state_d  = SMul;
        end
      end
      SMul: begin
        if (mul_done) begin
          step_d = step_q + 1'b1;
          case (step_q)
            3'd1:    det_d = tmp_q - mul_p;
            3'd3:    na_d  = tmp_q - mul_p;
            3'd5:    nb_d  = tmp_q - mul_p;
            default: tmp_d = mul_p;
          endcase
          if (step_q == 3'd5) begin
            state_d = SEval;
          end else begin
            mstart_d = 1'b1;
          end
        end
      end
      SEval: begin
        step_d = '0;
        if (det_q == '0) begin
          rs_d    = StSingular;
          state_d = SDone;
        end else if (nega || negb) begin
          rs_d    = StNegative;
          state_d = SDone;
        end else begin
          dstart_d = 1'b1;
          state_d  = SDiv;
        end
      end
      SDiv: begin
        if (div_done) begin
          if (step_q == 3'd0) begin
            ra_d     = div_q;
            step_d   = 3'd1;
            dstart_d = 1'b1;
          end else begin
            rb_d    = div_q;
            rs_d    = StOk;
            state_d = SDone;
          end
        end
      end
      SDone: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          odata_d = {rb_q, ra_q};
          ouser_d = rs_q;
          sxx_d   = '0;
          syy_d   = '0;
          sxy_d   = '0;
          sxz_d   = '0;
          syz_d   = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      sxx_q    <= '0;
      syy_q    <= '0;
      sxy_q    <= '0;
      sxz_q    <= '0;
      syz_q    <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      step_q   <= '0;
      mstart_q <= 1'b0;
      dstart_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      sxx_q    <= sxx_d;
      syy_q    <= syy_d;
      sxy_q    <= sxy_d;
      sxz_q    <= sxz_d;
      syz_q    <= syz_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      step_q   <= step_d;
      mstart_q <= mstart_d;
      dstart_q <= dstart_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= s_axis_tdata[CB-1:0];
      y_q    <= s_axis_tdata[2*CB-1:CB];
      z_q    <= s_axis_tdata[3*CB-1:2*CB];
      last_q <= s_axis_tlast;
    end
    tmp_q   <= tmp_d;
    det_q   <= det_d;
    na_q    <= na_d;
    nb_q    <= nb_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    rs_q    <= rs_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule
